// ----- rtl/core/bra_pkg.sv -----
`default_nettype none

package bra_pkg;

  // Default map size in units.
  localparam int unsigned MapBitsDefault = 1024;

  // Storage word and field widths.
  localparam int unsigned WordW = 32;
  localparam int unsigned BitSelW = 5;
  localparam int unsigned OpW = 3;
  localparam int unsigned IdxW = 10;
  localparam int unsigned CntW = 11;
  localparam int unsigned CfgW = 8;

  // The active length is at most 255 bytes of eight units, so it fits in 11 bits.
  localparam int unsigned LenW = 11;
  // Sums of an index and a count, and running lengths of free units.
  localparam int unsigned SumW = 12;
  localparam int unsigned RunW = 12;
  // Word counter for scans inside the active length (at most 64 words).
  localparam int unsigned WcW = 7;

  localparam logic [CfgW-1:0] MapBytesReset = 8'd128;

  // Operation codes.
  localparam logic [OpW-1:0] OP_CHECK   = 3'd0;
  localparam logic [OpW-1:0] OP_FIND    = 3'd1;
  localparam logic [OpW-1:0] OP_SET     = 3'd2;
  localparam logic [OpW-1:0] OP_CLR     = 3'd3;
  localparam logic [OpW-1:0] OP_CLR_ALL = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIPE,
    ST_CHECK,
    ST_FIND,
    ST_RANGE,
    ST_DONE
  } bra_state_e;

  typedef struct packed {
    logic [IdxW-1:0] found_index;
    logic            found;
    logic            bit_value;
    logic            out_of_range;
  } bra_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/bra_req_if.sv -----
`default_nettype none

interface bra_req_if import bra_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OpW-1:0]  operation;
  logic [IdxW-1:0] index;
  logic [CntW-1:0] count;

  modport source (output valid, output operation, output index, output count, input ready);
  modport sink (input valid, input operation, input index, input count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bra_rsp_if.sv -----
`default_nettype none

interface bra_rsp_if import bra_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] found_index;
  logic            found;
  logic            bit_value;
  logic            out_of_range;

  modport source (
    output valid, output found_index, output found, output bit_value, output out_of_range,
    input ready
  );
  modport sink (
    input valid, input found_index, input found, input bit_value, input out_of_range,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/bra_cfg_if.sv -----
`default_nettype none

interface bra_cfg_if import bra_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bitmap_run_allocator_core.sv -----
`default_nettype none

// First-fit run allocator over a bitmap of units (1 = used, 0 = free).
// Requests arrive on req_i (operation, index, count); every request produces
// exactly one transaction on rsp_o (found_index, found, bit_value, out_of_range).
// cfg_i writes map_bytes, the number of bytes of the map in use; it is always
// ready and is meant to be written only while the block is idle.
// The map lives in one RAM of 32-bit words with a registered read. A request is
// taken only in the idle state and the block works on one request at a time:
//   check             reads the word that holds the unit and loads its bit
//   find              scans W words, W = words scanned until the run is found
//                     (at most ceil(length / 32))
//   set / clear range writes W words, W = words the range touches, one
//                     read-modify-write per cycle
//   clear all         zeroes every word of the map, one word zeroed per cycle
//   errors and undefined operations: go straight to loading the result
// The next request is accepted in the cycle after the result is loaded into
// the output register, so a result may wait on rsp_o while new work starts.
// If a result is still waiting when the next one is finished, the block holds
// it and accepts nothing until the receiver takes the older transaction.
// After reset the block zeroes every word of the map, and during that pass
// req_i is not ready; configuration writes are still taken.
module bitmap_run_allocator_core import bra_pkg::*; #(
  parameter int unsigned MAP_BITS = MapBitsDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  bra_cfg_if.sink    cfg_i,
  bra_req_if.sink    req_i,
  bra_rsp_if.source  rsp_o
);

  localparam int unsigned WordCount = (MAP_BITS + WordW - 1) / WordW;
  localparam int unsigned AddrW     = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int unsigned ByteLimit = MAP_BITS / 8;
  localparam int unsigned ByteCap   = (ByteLimit > 255) ? 255 : ByteLimit;
  localparam logic [CfgW-1:0]  ByteCapV = CfgW'(ByteCap);
  localparam logic [AddrW-1:0] LastWord = AddrW'(WordCount - 1);

  // Configuration register and the active length derived from it.
  logic [CfgW-1:0] map_bytes_q;
  logic [CfgW-1:0] bytes_eff;
  logic [LenW-1:0] len;
  logic [SumW-1:0] len_ext;
  logic [SumW-1:0] len_round;
  logic [WcW-1:0]  words_total;

  // Control state.
  bra_state_e       state_q, state_d;
  logic [AddrW-1:0] wipe_q, wipe_d;
  logic             emit_q, emit_d;
  logic             out_valid_q, out_valid_d;

  // Request and scan registers.
  logic [OpW-1:0]     op_q, op_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [WcW-1:0]     wc_q, wc_d;
  logic [WcW-1:0]     last_q, last_d;
  logic [BitSelW-1:0] end_lo_q, end_lo_d;
  logic [RunW-1:0]    run_q, run_d;
  bra_rsp_t           res_q, res_d;
  bra_rsp_t           out_q, out_d;

  // Request decode.
  logic            req_fire;
  logic            out_free;
  logic [SumW-1:0] req_end;
  logic [SumW-1:0] req_end_m1;
  logic            idx_oor;
  logic            rng_oor;

  // Memory ports.
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [WordW-1:0] mem_rdata;

  // Scan and range datapath.
  logic [WordW-1:0]   valid_mask;
  logic [WordW-1:0]   scan_used;
  logic [RunW-1:0]    run_at [WordW];
  logic [WordW-1:0]   hit_vec;
  logic               hit_any;
  logic [BitSelW-1:0] hit_pos;
  logic [SumW-1:0]    found_sum;
  logic [BitSelW-1:0] rng_lo;
  logic [BitSelW-1:0] rng_hi;
  logic [WordW-1:0]   rng_mask;
  logic               last_word;

  // ---------------------------------------------------------------------------
  // Configuration: lengths above the map saturate to the map size, capped at 255 bytes.
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_bytes_q <= MapBytesReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      map_bytes_q <= cfg_i.data;
    end
  end

  assign bytes_eff   = (map_bytes_q > ByteCapV) ? ByteCapV : map_bytes_q;
  assign len         = {bytes_eff, 3'b000};
  assign len_ext     = {1'b0, len};
  assign len_round   = len_ext + SumW'(WordW - 1);
  assign words_total = len_round[SumW-1:BitSelW];

  // ---------------------------------------------------------------------------
  // Handshakes and request decode.
  // ---------------------------------------------------------------------------
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign req_end    = SumW'(req_i.index) + SumW'(req_i.count);
  assign req_end_m1 = req_end - SumW'(1);
  assign idx_oor    = SumW'(req_i.index) >= len_ext;
  assign rng_oor    = idx_oor || (req_end > len_ext);

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.found_index  = out_q.found_index;
  assign rsp_o.found        = out_q.found;
  assign rsp_o.bit_value    = out_q.bit_value;
  assign rsp_o.out_of_range = out_q.out_of_range;

  // ---------------------------------------------------------------------------
  // Find datapath: one 32-bit word per cycle. Units past the active length
  // count as used, so a run can never reach beyond it. For every position the
  // length of the free run ending there is either the run carried in from
  // earlier words plus the position plus one, or the distance to the nearest
  // used unit below it in this word.
  // ---------------------------------------------------------------------------
  assign last_word = (wc_q == last_q);

  always_comb begin
    valid_mask = '1;
    if (last_word && (len[BitSelW-1:0] != '0)) begin
      valid_mask = ~({WordW{1'b1}} << len[BitSelW-1:0]);
    end
  end

  assign scan_used = mem_rdata | ~valid_mask;

  always_comb begin
    for (int j = 0; j < WordW; j++) begin
      run_at[j] = run_q + RunW'(j + 1);
      for (int k = 0; k < WordW; k++) begin
        if ((k <= j) && scan_used[k]) begin
          run_at[j] = RunW'(j - k);
        end
      end
      hit_vec[j] = run_at[j] >= RunW'(cnt_q);
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int j = WordW - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_pos = BitSelW'(j);
      end
    end
  end

  assign hit_any = |hit_vec;
  // The run ends at word * 32 + position; its start is count - 1 units lower.
  assign found_sum = {wc_q[SumW-BitSelW-1:0], hit_pos} + SumW'(1) - SumW'(cnt_q);

  // ---------------------------------------------------------------------------
  // Range datapath: the mask of the current word covered by the range.
  // ---------------------------------------------------------------------------
  assign rng_lo   = (wc_q == WcW'(idx_q[IdxW-1:BitSelW])) ? idx_q[BitSelW-1:0] : '0;
  assign rng_hi   = last_word ? end_lo_q : '1;
  assign rng_mask = ({WordW{1'b1}} << rng_lo) & ({WordW{1'b1}} >> (~rng_hi));

  // ---------------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          unique case (req_i.operation) inside
            OP_CHECK: state_d = idx_oor ? ST_DONE : ST_CHECK;
            OP_FIND: begin
              state_d = ((req_i.count == '0) || (words_total == '0)) ? ST_DONE : ST_FIND;
            end
            OP_SET, OP_CLR: begin
              state_d = (rng_oor || (req_i.count == '0)) ? ST_DONE : ST_RANGE;
            end
            OP_CLR_ALL: state_d = ST_WIPE;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_WIPE: begin
        if (wipe_q == LastWord) begin
          state_d = emit_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_CHECK: state_d = ST_DONE;
      ST_FIND: begin
        if (hit_any || last_word) begin
          state_d = ST_DONE;
        end
      end
      ST_RANGE: begin
        if (last_word) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memory controls. A scan reads the next word while the current one is
  // processed; a range writes word w while reading word w + 1, so a read and a
  // write never meet on the same entry.
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AddrW'(wc_q);
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = AddrW'(wc_q + WcW'(1));
    unique case (state_q) inside
      ST_IDLE: begin
        mem_re    = req_fire;
        mem_raddr = (req_i.operation == OP_FIND) ? '0 : AddrW'(req_i.index[IdxW-1:BitSelW]);
      end
      ST_WIPE: begin
        mem_we    = 1'b1;
        mem_waddr = wipe_q;
      end
      ST_FIND: begin
        mem_re = !last_word && !hit_any;
      end
      ST_RANGE: begin
        mem_we    = 1'b1;
        mem_wdata = (op_q == OP_SET) ? (mem_rdata | rng_mask) : (mem_rdata & ~rng_mask);
        mem_re    = !last_word;
      end
      ST_CHECK, ST_DONE: begin
        mem_re = 1'b0;
      end
      default: mem_re = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Register updates.
  // ---------------------------------------------------------------------------
  always_comb begin
    wipe_d      = wipe_q;
    emit_d      = emit_q;
    op_d        = op_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    wc_d        = wc_q;
    last_d      = last_q;
    end_lo_d    = end_lo_q;
    run_d       = run_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          op_d     = req_i.operation;
          idx_d    = req_i.index;
          cnt_d    = req_i.count;
          run_d    = '0;
          end_lo_d = req_end_m1[BitSelW-1:0];
          res_d    = '0;
          wipe_d   = '0;
          emit_d   = 1'b1;
          if (req_i.operation == OP_FIND) begin
            wc_d   = '0;
            last_d = words_total - WcW'(1);
          end else begin
            wc_d   = WcW'(req_i.index[IdxW-1:BitSelW]);
            last_d = WcW'(req_end_m1[LenW-1:BitSelW]);
          end
          case (req_i.operation) inside
            OP_CHECK:       res_d.out_of_range = idx_oor;
            OP_FIND:        res_d.out_of_range = (req_i.count == '0);
            OP_SET, OP_CLR: res_d.out_of_range = rng_oor;
            default:        res_d.out_of_range = 1'b0;
          endcase
        end
      end
      ST_WIPE: begin
        wipe_d = wipe_q + AddrW'(1);
      end
      ST_CHECK: begin
        res_d.bit_value = mem_rdata[idx_q[BitSelW-1:0]];
      end
      ST_FIND: begin
        if (hit_any) begin
          res_d.found       = 1'b1;
          res_d.found_index = found_sum[IdxW-1:0];
        end else begin
          run_d = run_at[WordW-1];
          wc_d  = wc_q + WcW'(1);
        end
      end
      ST_RANGE: begin
        wc_d = wc_q + WcW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
        end
      end
      default: begin
        wc_d = wc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WIPE;
      wipe_q      <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wipe_q      <= wipe_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    wc_q     <= wc_d;
    last_q   <= last_d;
    end_lo_q <= end_lo_d;
    run_q    <= run_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  bra_ram #(
    .Width (WordW),
    .Depth (WordCount)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q != ST_IDLE)
    else $error("accepted request did not start any work");

  a_no_write_on_read_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIND || state_q == ST_CHECK) |-> !mem_we)
    else $error("map written during a check or find");

  a_range_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RANGE |-> wc_q <= last_q)
    else $error("range write walked past its last word");

  a_found_not_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.found) |-> !rsp_o.out_of_range)
    else $error("found run reported together with out of range");

endmodule

`default_nettype wire

// ----- rtl/core/bra_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered read data.
module bra_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
